// File: rtl/pic_pkg.sv
package pic_pkg;

	localparam int FIELD_W     = 32;
	localparam int COORD_WIDTH = 32;
	localparam int DIFF_W      = COORD_WIDTH + 1;
	localparam int PROD_W      = 2 * DIFF_W;
	localparam int JOB_DEPTH   = 4;
	localparam int JOB_AW      = $clog2(JOB_DEPTH);
	localparam int RES_DEPTH   = 4;
	localparam int RES_AW      = $clog2(RES_DEPTH);

	typedef enum logic [1:0] {
		OP_INNER  = 2'd0,
		OP_OUTER  = 2'd1,
		OP_POINT  = 2'd2,
		OP_VERTEX = 2'd3
	} op_t;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]      diff_t;
	typedef logic [DIFF_W-1:0]             mag_t;
	typedef logic [PROD_W-1:0]             prod_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	typedef struct packed {
		coord_t xmin;
		coord_t ymin;
		coord_t xmax;
		coord_t ymax;
	} box_t;

	// One vertex worth of work: edge prev->cur, and closing edge cur->first
	typedef struct packed {
		point_t prev;
		point_t cur;
		point_t first;
		point_t pt;
		logic   edge_en;
		logic   last;
		logic   box_ok;
	} job_t;

endpackage

// File: rtl/point_in_contour_crossing_test.sv
// A vertex with last set shows its result (empty low) after the job queue, the edge pipe
// and the result queue. Throughput: one item per cycle unless a queue fills; each vertex
// runs both of its edge tests in parallel through a 3-stage subtract/multiply pipe, and a
// 4-entry queue decouples the front. Loads and non-final vertices produce no result.
// Reset (arst_n low, asynchronous) empties both queues, clears the contour in progress
// and the crossing parity, and zeroes both boxes and the test point.
module point_in_contour_crossing_test (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [1:0]                         opcode,
	input  logic signed [pic_pkg::FIELD_W-1:0] x_a,
	input  logic signed [pic_pkg::FIELD_W-1:0] y_a,
	input  logic signed [pic_pkg::FIELD_W-1:0] x_b,
	input  logic signed [pic_pkg::FIELD_W-1:0] y_b,
	input  logic                               last,
	output logic                               empty,
	input  logic                               pop,
	output logic                               is_inside
);
	import pic_pkg::*;

	job_t job_in;
	job_t job_out;
	logic job_push;
	logic job_pop;
	logic job_empty;
	logic accept;

	assign accept = push && !full;

	pic_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.opcode   (op_t'(opcode)),
		.x_a      (x_a),
		.y_a      (y_a),
		.x_b      (x_b),
		.y_b      (y_b),
		.last     (last),
		.job      (job_in),
		.job_push (job_push)
	);

	pic_job_q u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (job_in),
		.pop    (job_pop),
		.dout   (job_out),
		.full   (full),
		.empty  (job_empty)
	);

	pic_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job_out),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.pop       (pop),
		.empty     (empty),
		.is_inside (is_inside)
	);

endmodule

// File: rtl/pic_front.sv
module pic_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  pic_pkg::op_t                    opcode,
	input  logic signed [pic_pkg::FIELD_W-1:0] x_a,
	input  logic signed [pic_pkg::FIELD_W-1:0] y_a,
	input  logic signed [pic_pkg::FIELD_W-1:0] x_b,
	input  logic signed [pic_pkg::FIELD_W-1:0] y_b,
	input  logic                            last,
	output pic_pkg::job_t                   job,
	output logic                            job_push
);
	import pic_pkg::*;

	box_t   in_box_q;
	box_t   out_box_q;
	point_t pt_q;
	point_t first_q;
	point_t prev_q;
	logic   have_first_q;

	coord_t xa, ya, xb, yb;
	point_t cur;

	assign xa = x_a[COORD_WIDTH-1:0];
	assign ya = y_a[COORD_WIDTH-1:0];
	assign xb = x_b[COORD_WIDTH-1:0];
	assign yb = y_b[COORD_WIDTH-1:0];
	assign cur = '{x: xa, y: ya};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_box_q     <= '0;
			out_box_q    <= '0;
			pt_q         <= '0;
			first_q      <= '0;
			prev_q       <= '0;
			have_first_q <= 1'b0;
		end else if (accept) begin
			unique case (opcode)
				OP_INNER: in_box_q <= '{xmin: xa, ymin: ya, xmax: xb, ymax: yb};
				OP_OUTER: out_box_q <= '{xmin: xa, ymin: ya, xmax: xb, ymax: yb};
				OP_POINT: pt_q <= cur;
				OP_VERTEX: begin
					if (!have_first_q)
						first_q <= cur;
					prev_q       <= cur;
					have_first_q <= !last;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		job.prev    = prev_q;
		job.cur     = cur;
		job.first   = have_first_q ? first_q : cur;
		job.pt      = pt_q;
		job.edge_en = have_first_q;
		job.last    = last;
		job.box_ok  = (in_box_q.xmin > out_box_q.xmin) && (in_box_q.ymin > out_box_q.ymin) &&
		              (in_box_q.xmax < out_box_q.xmax) && (in_box_q.ymax < out_box_q.ymax);
	end

	assign job_push = accept && (opcode == OP_VERTEX);

endmodule

// File: rtl/pic_job_q.sv
module pic_job_q (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pic_pkg::job_t din,
	input  logic          pop,
	output pic_pkg::job_t dout,
	output logic          full,
	output logic          empty
);
	import pic_pkg::*;

	job_t              mem_q [JOB_DEPTH];
	logic [JOB_AW-1:0] wr_q;
	logic [JOB_AW-1:0] rd_q;
	logic [JOB_AW:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (cnt_q == (JOB_AW+1)'(JOB_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/pic_edge.sv
module pic_edge (
	input  logic              clk,
	input  logic              en,
	input  pic_pkg::point_t   p1,
	input  pic_pkg::point_t   p2,
	input  pic_pkg::point_t   pt,
	output logic              counts
);
	import pic_pkg::*;

	// s1: raw differences
	diff_t a_s1, b_s1, d_s1, dx_s1, rx_s1, r2_s1;
	// s2: flags and magnitudes
	logic  rej_s2, horiz_s2, hcnt_s2, dxn_s2, rxn_s2;
	mag_t  amag_s2, dmag_s2, dxm_s2, rxm_s2;
	// s3: products
	logic  fixed_s3, fval_s3, dxn_s3, rxn_s3;
	prod_t pl_s3, pr_s3;

	logic  nl, nr, le;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= diff_t'(pt.y) - diff_t'(p1.y);
			b_s1  <= diff_t'(pt.y) - diff_t'(p2.y);
			d_s1  <= diff_t'(p2.y) - diff_t'(p1.y);
			dx_s1 <= diff_t'(p2.x) - diff_t'(p1.x);
			rx_s1 <= diff_t'(pt.x) - diff_t'(p1.x);
			r2_s1 <= diff_t'(pt.x) - diff_t'(p2.x);

			// both ends on the same side of the test row: no crossing
			rej_s2   <= (a_s1 < 0 && b_s1 < 0) || (a_s1 > 0 && b_s1 > 0);
			horiz_s2 <= (d_s1 == '0);
			hcnt_s2  <= (a_s1 == '0) && (rx_s1 > 0 || r2_s1 > 0);
			// flip a with d so that d is positive
			amag_s2  <= (d_s1 < 0) ? mag_t'(-a_s1) : mag_t'(a_s1);
			dmag_s2  <= (d_s1 < 0) ? mag_t'(-d_s1) : mag_t'(d_s1);
			dxn_s2   <= (dx_s1 < 0);
			dxm_s2   <= (dx_s1 < 0) ? mag_t'(-dx_s1) : mag_t'(dx_s1);
			rxn_s2   <= (rx_s1 < 0);
			rxm_s2   <= (rx_s1 < 0) ? mag_t'(-rx_s1) : mag_t'(rx_s1);

			fixed_s3 <= rej_s2 || horiz_s2;
			fval_s3  <= !rej_s2 && hcnt_s2;
			dxn_s3   <= dxn_s2;
			rxn_s3   <= rxn_s2;
			pl_s3    <= amag_s2 * dxm_s2;
			pr_s3    <= rxm_s2 * dmag_s2;
		end
	end

	// a*dx <= rx*d in sign-magnitude form; a zero product is never negative
	always_comb begin
		nl = dxn_s3 && (pl_s3 != '0);
		nr = rxn_s3 && (pr_s3 != '0);
		if (nl != nr)
			le = nl;
		else if (!nl)
			le = (pl_s3 <= pr_s3);
		else
			le = (pl_s3 >= pr_s3);
		counts = fixed_s3 ? fval_s3 : le;
	end

endmodule

// File: rtl/pic_back.sv
module pic_back (
	input  logic          clk,
	input  logic          arst_n,
	input  pic_pkg::job_t job,
	input  logic          job_empty,
	output logic          job_pop,
	input  logic          pop,
	output logic          empty,
	output logic          is_inside
);
	import pic_pkg::*;

	logic              v_s1, v_s2, v_s3;
	logic              edge_en_s1, edge_en_s2, edge_en_s3;
	logic              last_s1, last_s2, last_s3;
	logic              box_ok_s1, box_ok_s2, box_ok_s3;
	logic              par_q;
	logic              c1, c2;
	logic              en, fire, par_new, rq_push, rq_pop, rq_full;

	logic              rq_mem_q [RES_DEPTH];
	logic [RES_AW-1:0] rq_wr_q;
	logic [RES_AW-1:0] rq_rd_q;
	logic [RES_AW:0]   rq_cnt_q;

	pic_edge u_edge_prev (
		.clk    (clk),
		.en     (en),
		.p1     (job.prev),
		.p2     (job.cur),
		.pt     (job.pt),
		.counts (c1)
	);

	pic_edge u_edge_close (
		.clk    (clk),
		.en     (en),
		.p1     (job.cur),
		.p2     (job.first),
		.pt     (job.pt),
		.counts (c2)
	);

	// hold the whole pipe only when a result has nowhere to go
	assign en      = !(v_s3 && last_s3 && rq_full);
	assign job_pop = en && !job_empty;
	assign fire    = en && v_s3;
	assign par_new = (edge_en_s3 & par_q) ^ (edge_en_s3 & c1) ^ (last_s3 & c2);
	assign rq_push = fire && last_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			edge_en_s1 <= job.edge_en;
			last_s1    <= job.last;
			box_ok_s1  <= job.box_ok;
			edge_en_s2 <= edge_en_s1;
			last_s2    <= last_s1;
			box_ok_s2  <= box_ok_s1;
			edge_en_s3 <= edge_en_s2;
			last_s3    <= last_s2;
			box_ok_s3  <= box_ok_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			par_q <= 1'b0;
		end else begin
			if (en) begin
				v_s1 <= !job_empty;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
			end
			if (fire)
				par_q <= last_s3 ? 1'b0 : par_new;
		end
	end

	assign rq_full   = (rq_cnt_q == (RES_AW+1)'(RES_DEPTH));
	assign empty     = (rq_cnt_q == '0);
	assign rq_pop    = pop && !empty;
	assign is_inside = rq_mem_q[rq_rd_q];

	always_ff @(posedge clk) begin
		if (rq_push)
			rq_mem_q[rq_wr_q] <= box_ok_s3 && par_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q  <= '0;
			rq_rd_q  <= '0;
			rq_cnt_q <= '0;
		end else begin
			if (rq_push)
				rq_wr_q <= rq_wr_q + 1'b1;
			if (rq_pop)
				rq_rd_q <= rq_rd_q + 1'b1;
			unique case ({rq_push, rq_pop})
				2'b10:   rq_cnt_q <= rq_cnt_q + 1'b1;
				2'b01:   rq_cnt_q <= rq_cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/pic_checker.sv
module pic_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic [1:0] opcode,
	input logic       last,
	input logic       empty,
	input logic       pop,
	input logic       is_inside
);
	import pic_pkg::*;

	logic [4:0] pend_q;
	logic       res_in;
	logic       res_out;

	assign res_in  = push && !full && (opcode == OP_VERTEX) && last;
	assign res_out = pop && !empty;

	// track results owed: final vertices transferred minus results taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			unique case ({res_in, res_out})
				2'b10:   pend_q <= pend_q + 1'b1;
				2'b01:   pend_q <= pend_q - 1'b1;
				default: ;
			endcase
		end
	end

	a_reset_clean: assert property (@(posedge clk)
		$rose(arst_n) |-> (empty && !full))
		else $error("queues not empty after reset");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (pend_q != '0))
		else $error("result shown with no final vertex outstanding");

	a_full_needs_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("full rose without an input transfer");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(is_inside)))
		else $error("waiting result changed or vanished");

endmodule

bind point_in_contour_crossing_test pic_checker u_pic_checker (.*);
